### hdl/assert_macros.svh
// assertion macros used by the rtl, clocked on clk with async reset arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/wrhp_pkg.sv
// constants, codes and types of the riff/wave header parser
package wrhp_pkg;

	localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	localparam logic [3:0]  HDR_LEN     = 4'd12;
	localparam logic [31:0] FMT_MIN_LEN = 32'd16;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD        = 2'd1;
	localparam logic [1:0] ST_INCOMPLETE = 2'd2;
	localparam logic [1:0] ST_ZERO_DIV   = 2'd3;

	typedef enum logic [3:0] {
		PH_FILE   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_BODY   = 4'b0100,
		PH_PAD    = 4'b1000
	} phase_t;

	typedef enum logic [4:0] {
		S_WALK = 5'b00001,
		S_MUL1 = 5'b00010,
		S_MUL2 = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} seq_t;

	// expected signature byte at file positions 0..3 and 8..11
	function automatic logic [7:0] sig_byte(input logic [3:0] p);
		logic [7:0] r;
		r = 8'h00;
		unique case (p)
			4'd0:    r = 8'h52;
			4'd1:    r = 8'h49;
			4'd2:    r = 8'h46;
			4'd3:    r = 8'h46;
			4'd8:    r = 8'h57;
			4'd9:    r = 8'h41;
			4'd10:   r = 8'h56;
			4'd11:   r = 8'h45;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### hdl/wav_riff_header_parser_unit.sv
// riff/wave header parser: byte walker, shared multiplier and serial divider
// Usage: the input channel (in_valid/in_ready, data_byte, last_byte) takes a
// wav file one byte per cycle while the walker runs; in_ready is high then.
// Header and chunk bytes are walked at one byte per cycle with no stall.
// After the byte flagged last_byte the block drops in_ready and finishes the
// file: a bad signature or incomplete file goes straight to the result stage,
// a good one first passes the shared multiplier (rate*channels, then
// times bits/8) and the one-bit-per-cycle restoring divider; the divider
// is skipped when the divisor wraps to 0.
// The result channel (out_valid/out_ready with status, channel_count,
// sample_rate, bits_per_sample, data_length, duration_seconds) is a
// registered output; the next file may stream in while a result waits.
// A finished result that meets a still-waiting earlier one holds in the
// result stage, with in_ready low, until the receiver takes the old one.
// Reset (arst_n low) clears the walker and drops any pending result.
module wav_riff_header_parser_unit
	import wrhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [15:0] bits_per_sample,
	output logic [31:0] data_length,
	output logic [31:0] duration_seconds
);

	`include "assert_macros.svh"

	seq_t        state_q;
	phase_t      ph_q, ph_n;
	logic [3:0]  pos_q, pos_n;
	logic        sig_q, sig_n;
	logic [2:0]  hbc_q, hbc_n;
	logic [31:0] kind_q, kind_n;
	logic [31:0] len_q, len_n;
	logic [31:0] body_q, body_n;
	logic [15:0] pend_ch_q, pend_ch_n;
	logic [31:0] pend_rate_q, pend_rate_n;
	logic [15:0] pend_bits_q, pend_bits_n;
	logic [15:0] kept_ch_q, kept_ch_n;
	logic [31:0] kept_rate_q, kept_rate_n;
	logic [15:0] kept_bits_q, kept_bits_n;
	logic [31:0] kept_data_q, kept_data_n;
	logic [1:0]  stat_q;
	logic        out_valid_q;
	logic        commit;
	logic [31:0] off;
	logic        fmt_long;

	logic [31:0] div_q, rem_q, quo_q;
	logic [4:0]  cnt_q;
	logic [31:0] mul_a, mul_p;
	logic [15:0] mul_b;
	logic [32:0] trial;

	logic        accept, done_fire;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_WALK);
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// next state of the chunk walker for the byte on the input
	always_comb begin
		ph_n        = ph_q;
		pos_n       = pos_q;
		sig_n       = sig_q;
		hbc_n       = hbc_q;
		kind_n      = kind_q;
		len_n       = len_q;
		body_n      = body_q;
		pend_ch_n   = pend_ch_q;
		pend_rate_n = pend_rate_q;
		pend_bits_n = pend_bits_q;
		kept_ch_n   = kept_ch_q;
		kept_rate_n = kept_rate_q;
		kept_bits_n = kept_bits_q;
		kept_data_n = kept_data_q;
		commit      = 1'b0;
		off         = len_q - body_q;
		fmt_long    = (kind_q == ID_FMT) && (len_q >= FMT_MIN_LEN);
		unique case (ph_q)
			PH_FILE: begin
				if ((pos_q < 4'd4 || (pos_q >= 4'd8 && pos_q < HDR_LEN)) &&
				    data_byte != sig_byte(pos_q))
					sig_n = 1'b0;
				pos_n = pos_q + 4'd1;
				if (pos_n >= HDR_LEN) begin
					ph_n  = PH_HEADER;
					hbc_n = 3'd0;
				end
			end
			PH_HEADER: begin
				if (!hbc_q[2])
					kind_n = {data_byte, kind_q[31:8]};
				else
					len_n = {data_byte, len_q[31:8]};
				hbc_n = hbc_q + 3'd1;
				if (hbc_n == 3'd0) begin
					if (len_n == 32'd0) begin
						commit = 1'b1;
					end else begin
						body_n = len_n;
						ph_n   = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (fmt_long && off < 32'd16) begin
					unique case (off[3:0])
						4'd2:    pend_ch_n[7:0]     = data_byte;
						4'd3:    pend_ch_n[15:8]    = data_byte;
						4'd4:    pend_rate_n[7:0]   = data_byte;
						4'd5:    pend_rate_n[15:8]  = data_byte;
						4'd6:    pend_rate_n[23:16] = data_byte;
						4'd7:    pend_rate_n[31:24] = data_byte;
						4'd14:   pend_bits_n[7:0]   = data_byte;
						4'd15:   pend_bits_n[15:8]  = data_byte;
						default: ;
					endcase
				end
				body_n = body_q - 32'd1;
				if (body_n == 32'd0) begin
					commit = 1'b1;
					ph_n   = len_q[0] ? PH_PAD : PH_HEADER;
					hbc_n  = 3'd0;
				end
			end
			default: begin
				ph_n  = PH_HEADER;
				hbc_n = 3'd0;
			end
		endcase
		if (commit) begin
			if (kind_n == ID_FMT && len_n >= FMT_MIN_LEN) begin
				kept_ch_n   = pend_ch_n;
				kept_rate_n = pend_rate_n;
				kept_bits_n = pend_bits_n;
			end else if (kind_n == ID_DATA) begin
				kept_data_n = len_n;
			end
		end
	end

	// shared multiplier, low 32 bits kept
	always_comb begin
		mul_a = kept_rate_q;
		mul_b = kept_ch_q;
		if (state_q == S_MUL2) begin
			mul_a = div_q;
			mul_b = {3'd0, kept_bits_q[15:3]};
		end
	end
	assign mul_p = 32'(mul_a * mul_b);

	assign trial = {rem_q, quo_q[31]} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WALK;
			ph_q        <= PH_FILE;
			pos_q       <= 4'd0;
			sig_q       <= 1'b1;
			hbc_q       <= 3'd0;
			kind_q      <= 32'd0;
			len_q       <= 32'd0;
			body_q      <= 32'd0;
			pend_ch_q   <= 16'd0;
			pend_rate_q <= 32'd0;
			pend_bits_q <= 16'd0;
			kept_ch_q   <= 16'd0;
			kept_rate_q <= 32'd0;
			kept_bits_q <= 16'd0;
			kept_data_q <= 32'd0;
			stat_q      <= ST_OK;
			out_valid_q <= 1'b0;
			cnt_q       <= 5'd0;
		end else begin
			if (done_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_WALK: begin
					if (accept) begin
						kept_ch_q   <= kept_ch_n;
						kept_rate_q <= kept_rate_n;
						kept_bits_q <= kept_bits_n;
						kept_data_q <= kept_data_n;
						if (last_byte) begin
							// walker back to its reset state for the next file
							ph_q        <= PH_FILE;
							pos_q       <= 4'd0;
							sig_q       <= 1'b1;
							hbc_q       <= 3'd0;
							kind_q      <= 32'd0;
							len_q       <= 32'd0;
							body_q      <= 32'd0;
							pend_ch_q   <= 16'd0;
							pend_rate_q <= 32'd0;
							pend_bits_q <= 16'd0;
							if (ph_n == PH_FILE || !sig_n) begin
								stat_q  <= ST_BAD;
								state_q <= S_DONE;
							end else if (kept_rate_n == 32'd0 || kept_data_n == 32'd0) begin
								stat_q  <= ST_INCOMPLETE;
								state_q <= S_DONE;
							end else begin
								stat_q  <= ST_OK;
								state_q <= S_MUL1;
							end
						end else begin
							ph_q        <= ph_n;
							pos_q       <= pos_n;
							sig_q       <= sig_n;
							hbc_q       <= hbc_n;
							kind_q      <= kind_n;
							len_q       <= len_n;
							body_q      <= body_n;
							pend_ch_q   <= pend_ch_n;
							pend_rate_q <= pend_rate_n;
							pend_bits_q <= pend_bits_n;
						end
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					cnt_q <= 5'd0;
					if (mul_p == 32'd0) begin
						stat_q  <= ST_ZERO_DIV;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_fire) begin
						kept_ch_q   <= 16'd0;
						kept_rate_q <= 32'd0;
						kept_bits_q <= 16'd0;
						kept_data_q <= 32'd0;
						state_q     <= S_WALK;
					end
				end
				default: state_q <= S_WALK;
			endcase
		end
	end

	// multiplier result, divider and result stage
	always_ff @(posedge clk) begin
		if (state_q == S_MUL1 || state_q == S_MUL2)
			div_q <= mul_p;
		if (state_q == S_MUL2) begin
			rem_q <= 32'd0;
			quo_q <= kept_data_q;
		end else if (state_q == S_DIV) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (done_fire) begin
			status <= stat_q;
			if (stat_q == ST_BAD) begin
				channel_count   <= 16'd0;
				sample_rate     <= 32'd0;
				bits_per_sample <= 16'd0;
				data_length     <= 32'd0;
			end else begin
				channel_count   <= kept_ch_q;
				sample_rate     <= kept_rate_q;
				bits_per_sample <= kept_bits_q;
				data_length     <= kept_data_q;
			end
			duration_seconds <= (stat_q == ST_OK) ? quo_q : 32'd0;
		end
	end

	`ASSERT_NEXT(a_last_leaves_walk, accept && last_byte, state_q != S_WALK)
	`ASSERT_NEXT(a_div_runs_full, state_q == S_DIV && cnt_q != 5'd31, state_q == S_DIV)
	`ASSERT_NOW(a_dur_zero_unless_ok, out_valid && status != ST_OK, duration_seconds == 32'd0)
	`ASSERT_NEXT(a_result_from_done, !out_valid && state_q != S_DONE, !out_valid)

endmodule
